// File: rtl/svmk_pkg.sv
// svmk_pkg: shared types, constants and constant functions for the SVM kernel evaluator.
// Depends on nothing; every module in rtl/ imports it.
package svmk_pkg;

  localparam int ELEM_W    = 16;
  localparam int ACC_W     = 48;
  localparam int TERM_W    = 34;
  localparam int GAMMA_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = ACC_W - 1;

  localparam int ELEM_FRAC_BITS  = 8;
  localparam int X_SHIFT         = 2 * ELEM_FRAC_BITS;
  localparam int X_W             = 23;
  localparam int PROD_W          = GAMMA_W + SUM_W;
  localparam logic [X_W-1:0] X_CAP = X_W'(1) << 22;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam logic [15:0] Q_MASK = 16'(((1 << EXP_IDX_W) - 1) << (16 - EXP_IDX_W));

  localparam int RES_W = 17;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_MODE = 2'd0,
    REG_GAMMA       = 2'd1
  } svmk_reg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic                    sat;
    logic                    mode;
  } svmk_entry_t;

  typedef struct packed {
    logic        push;
    svmk_entry_t entry;
  } svmk_push_t;

  typedef struct packed {
    logic        valid;
    svmk_entry_t entry;
  } svmk_head_t;

  typedef logic [29:0] pow_c_t [16];

  function automatic longint unsigned isqrt64(longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bt;
    v   = v_in;
    res = 0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // c[k] = 2^-(2^(k-16)) in Q.30, by repeated square roots
  function automatic pow_c_t pow_consts();
    pow_c_t          c;
    longint unsigned t;
    t = 64'd1 << 29;
    for (int k = 15; k >= 0; k--) begin
      t    = isqrt64(t << 30);
      c[k] = 30'(t);
    end
    return c;
  endfunction

  localparam pow_c_t POW_C = pow_consts();

endpackage

// File: rtl/svmk_front.sv
// svmk_front: accepts element pairs, forms the per-pair term and keeps the saturating sum.
// Depends on svmk_pkg; pushes finished sums into svmk_queue.
module svmk_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [svmk_pkg::ELEM_W-1:0] in_a_elem,
  input  logic signed [svmk_pkg::ELEM_W-1:0] in_b_elem,
  input  logic                           in_last,
  input  logic                           kernel_mode,
  input  logic                           q_full,
  output svmk_pkg::svmk_push_t           push
);
  import svmk_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [TERM_W-1:0] term_r;
  logic                     p_valid_r;
  logic                     p_last_r;
  logic                     p_mode_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     flag_r;

  logic signed [ELEM_W:0]   a_ext;
  logic signed [ELEM_W:0]   b_ext;
  logic signed [ELEM_W:0]   diff;
  logic signed [ELEM_W:0]   op_a;
  logic signed [ELEM_W:0]   op_b;
  logic signed [TERM_W-1:0] term_nxt;
  logic        [ACC_W:0]    sum_wide;
  logic signed [ACC_W-1:0]  acc_sat;
  logic                     ovf;
  logic                     consume;
  logic                     accept;

  always_comb begin
    a_ext    = {in_a_elem[ELEM_W-1], in_a_elem};
    b_ext    = {in_b_elem[ELEM_W-1], in_b_elem};
    diff     = a_ext - b_ext;
    op_a     = kernel_mode ? diff : a_ext;
    op_b     = kernel_mode ? diff : b_ext;
    term_nxt = op_a * op_b;
  end

  always_comb begin
    sum_wide = {acc_r[ACC_W-1], acc_r} +
               {{(ACC_W+1-TERM_W){term_r[TERM_W-1]}}, term_r};
    ovf      = sum_wide[ACC_W] != sum_wide[ACC_W-1];
    if (!ovf) begin
      acc_sat = sum_wide[ACC_W-1:0];
    end else if (sum_wide[ACC_W]) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = ACC_MAX;
    end
  end

  assign consume  = p_valid_r && !(p_last_r && q_full);
  assign in_ready = !p_valid_r || consume;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push.push        = consume && p_last_r;
    push.entry.acc   = acc_sat;
    push.entry.sat   = flag_r || ovf;
    push.entry.mode  = p_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      acc_r     <= '0;
      flag_r    <= 1'b0;
    end else begin
      if (accept) begin
        p_valid_r <= 1'b1;
      end else if (consume) begin
        p_valid_r <= 1'b0;
      end
      if (consume) begin
        if (p_last_r) begin
          acc_r  <= '0;
          flag_r <= 1'b0;
        end else begin
          acc_r  <= acc_sat;
          flag_r <= flag_r || ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      term_r   <= term_nxt;
      p_last_r <= in_last;
      p_mode_r <= kernel_mode;
    end
  end

endmodule

// File: rtl/svmk_queue.sv
// svmk_queue: two-entry queue of finished sums between the front and the back.
// Depends on svmk_pkg.
module svmk_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  svmk_pkg::svmk_push_t push,
  input  logic                 pop,
  output svmk_pkg::svmk_head_t head,
  output logic                 full
);
  import svmk_pkg::*;

  svmk_entry_t mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign full       = count_r == 2'd2;
  assign head.valid = count_r != 2'd0;
  assign head.entry = mem_r[rd_ptr_r];
  assign do_push    = push.push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

// File: rtl/svmk_back.sv
// svmk_back: turns a queued sum into a result word; linear passes through, RBF runs exp(-x).
// Depends on svmk_pkg; pops from svmk_queue and owns the output register.
module svmk_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [svmk_pkg::GAMMA_W-1:0]        gamma,
  input  svmk_pkg::svmk_head_t                head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [svmk_pkg::ACC_W-1:0]   out_kernel_value,
  output logic                                out_overflow
);
  import svmk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MLO,
    S_MHI,
    S_SCALE,
    S_LOG,
    S_POW,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [SUM_W-1:0]        sum_r;
  logic                    sat_r;
  logic [47:0]             prod_lo_r;
  logic [46:0]             prod_hi_r;
  logic [X_W-1:0]          x_r;
  logic [7:0]              n_r;
  logic [15:0]             q_r;
  logic [30:0]             r_r;
  logic [3:0]              k_r;
  logic                    out_valid_r;
  logic signed [ACC_W-1:0] value_r;
  logic                    ovf_r;

  logic                    out_free;
  logic                    load_out;
  logic [PROD_W-1:0]       prod_full;
  logic [PROD_W-1:0]       prod_shr;
  logic [X_W-1:0]          x_nxt;
  logic [39:0]             y_mul;
  logic [61:0]             r_mul;
  logic [30:0]             r_nxt;
  logic [5:0]              rnd_sh;
  logic [44:0]             rnd_sum;
  logic [44:0]             rnd_shr;
  logic [RES_W-1:0]        res;

  assign out_free         = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_kernel_value = value_r;
  assign out_overflow     = ovf_r;

  assign load_out = (state_r == S_IDLE && pop && !head.entry.mode) ||
                    (state_r == S_DONE && out_free);

  always_comb begin
    pop = 1'b0;
    if (state_r == S_IDLE && head.valid) begin
      pop = head.entry.mode || out_free;
    end
  end

  always_comb begin
    prod_full = {prod_hi_r, 24'd0} + PROD_W'(prod_lo_r);
    prod_shr  = prod_full >> X_SHIFT;
    x_nxt     = (prod_shr > PROD_W'(X_CAP)) ? X_CAP : prod_shr[X_W-1:0];
    y_mul     = 40'(x_r) * 40'(LOG2E_Q16) + 40'd32768;
    r_mul     = 62'(r_r) * 62'(POW_C[k_r]) + (62'd1 << 29);
    r_nxt     = r_mul[60:30];
    rnd_sh    = 6'(n_r[4:0]) + 6'd13;
    rnd_sum   = 45'(r_r) + (45'd1 << rnd_sh);
    rnd_shr   = rnd_sum >> (rnd_sh + 6'd1);
    res       = (n_r >= 8'd31) ? '0 : rnd_shr[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            if (head.entry.mode) begin
              sum_r   <= head.entry.acc[ACC_W-1] ? '0 : head.entry.acc[SUM_W-1:0];
              sat_r   <= head.entry.sat;
              state_r <= S_MLO;
            end else begin
              value_r     <= head.entry.acc;
              ovf_r       <= head.entry.sat;
            end
          end
        end
        S_MLO: begin
          prod_lo_r <= 48'(gamma) * 48'(sum_r[23:0]);
          state_r   <= S_MHI;
        end
        S_MHI: begin
          prod_hi_r <= 47'(gamma) * 47'(sum_r[SUM_W-1:24]);
          state_r   <= S_SCALE;
        end
        S_SCALE: begin
          x_r     <= x_nxt;
          state_r <= S_LOG;
        end
        S_LOG: begin
          n_r     <= y_mul[39:32];
          q_r     <= y_mul[31:16] & Q_MASK;
          r_r     <= 31'd1 << 30;
          k_r     <= 4'd15;
          state_r <= S_POW;
        end
        S_POW: begin
          if (q_r[k_r]) begin
            r_r <= r_nxt;
          end
          if (k_r == 4'd0) begin
            state_r <= S_DONE;
          end else begin
            k_r <= k_r - 4'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            value_r     <= ACC_W'(res);
            ovf_r       <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/svm_kernel_eval.sv
// svm_kernel_eval: top level of the SVM kernel evaluator; holds the config registers.
// Depends on svmk_pkg, svmk_front, svmk_queue and svmk_back.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_a_elem, in_b_elem, in_last
//   out      out_valid/out_ready  out_kernel_value, out_overflow
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// Element pairs are taken one per cycle, but not while a held last pair waits on a full queue;
// the multiply and the saturating add are two stages. An RBF result passes through the
// 16-step power-of-two multiply loop in the back end.
// The back end takes no new sum until its RBF result is out; the 2-entry queue absorbs bursts.
// Reset is synchronous, active low, and clears the sum, the queue and the output valid flag.
module svm_kernel_eval (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [svmk_pkg::ELEM_W-1:0]  in_a_elem,
  input  logic signed [svmk_pkg::ELEM_W-1:0]  in_b_elem,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [svmk_pkg::ACC_W-1:0]   out_kernel_value,
  output logic                                out_overflow,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [svmk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [svmk_pkg::GAMMA_W-1:0]        cfg_wdata
);
  import svmk_pkg::*;

  logic               kernel_mode_r;
  logic [GAMMA_W-1:0] gamma_r;
  svmk_push_t         push;
  svmk_head_t         head;
  logic               q_full;
  logic               pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_mode_r <= 1'b0;
      gamma_r       <= GAMMA_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KERNEL_MODE: kernel_mode_r <= cfg_wdata[0];
        REG_GAMMA:       gamma_r       <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  svmk_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_a_elem   (in_a_elem),
    .in_b_elem   (in_b_elem),
    .in_last     (in_last),
    .kernel_mode (kernel_mode_r),
    .q_full      (q_full),
    .push        (push)
  );

  svmk_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  svmk_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .gamma            (gamma_r),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kernel_value (out_kernel_value),
    .out_overflow     (out_overflow)
  );

endmodule

// File: tb/sv/svm_kernel_eval_test.sv
// Self-checking testbench for svm_kernel_eval: linear and RBF kernel values from streamed pairs.
// Drives directed rows and random traffic; checks against a local model.
// Depends on svmk_pkg and the svm_kernel_eval RTL.
`timescale 1ns / 1ps

module svm_kernel_eval_test;
  import svmk_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_MODE   = REG_KERNEL_MODE;
  localparam logic [CFG_IDX_W-1:0] IDX_GAMMA  = REG_GAMMA;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE3 = 2'd3;

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam int SCALE_SHIFT = 2 * ELEM_FRAC_BITS;
  localparam longint unsigned X_LIMIT = 64'd1 << 22;
  localparam longint unsigned LOG2E = 64'd94548;
  localparam longint unsigned TABLE_DEPTH = EXP_TABLE_DEPTH;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 1300;
  localparam longint RUN_LIMIT_NS = 20_000_000;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic                    ovf;
  } kernel_result_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [GAMMA_W-1:0]      reg_data;
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic                    last;
    logic                    typed;
    logic signed [ACC_W-1:0] value;
    logic                    ovf;
  } plan_row_t;

  // Typed rows: reset defaults, extremes, gamma zero and gamma saturation.
  localparam plan_row_t DIRECTED_PLAN [28] = '{
    '{ROW_WORD, '0, '0, 16'sh0100, 16'sh0100, 1'b1, 1'b1, 48'sd65536, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh8000, 16'sh8000, 1'b1, 1'b1, 48'sd1073741824, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, -48'sd1073709056, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0000, 16'sh0000, 1'b1, 1'b1, 48'sd0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd300, -16'sd7, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, -16'sd1234, 16'sd555, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_REG, IDX_MODE, 24'd1, '0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh1234, 16'sh1234, 1'b1, 1'b1, 48'sd65536, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0100, 16'sh0000, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0080, 16'sh0000, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0000, 16'sh0080, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_REG, IDX_GAMMA, 24'd0, '0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 48'sd65536, 1'b0},
    '{ROW_REG, IDX_GAMMA, 24'hFFFFFF, '0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 48'sd0, 1'b0},
    '{ROW_REG, IDX_GAMMA, 24'h000100, '0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0300, -16'sh0200, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_REG, IDX_SPARE2, 24'hFFFFFF, '0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_REG, IDX_SPARE3, 24'h000000, '0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0040, 16'sh0010, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0200, 16'sh0100, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_REG, IDX_MODE, 24'hFFFFFE, '0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0100, 16'sh0300, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, -16'sd500, 16'sd900, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_REG, IDX_MODE, 24'h000001, '0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd7, -16'sd7, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_REG, IDX_GAMMA, 24'h010000, '0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_REG, IDX_MODE, 24'h000000, '0, '0, 1'b0, 1'b0, '0, 1'b0}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [ELEM_W-1:0] in_a_elem;
  logic signed [ELEM_W-1:0] in_b_elem;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [ACC_W-1:0]  out_kernel_value;
  logic                     out_overflow;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [GAMMA_W-1:0]       cfg_wdata;

  svm_kernel_eval dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_a_elem        (in_a_elem),
    .in_b_elem        (in_b_elem),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kernel_value (out_kernel_value),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // local copy of the block state and registers
  bit                      pred_rbf;
  logic [GAMMA_W-1:0]      pred_gamma;
  logic signed [ACC_W-1:0] pred_acc;
  bit                      pred_sat;
  longint unsigned         exp_root [16];

  kernel_result_t pending [$];
  kernel_result_t oldest;

  bit quiet;
  bit hold_request;
  int errors;
  int word_count;
  int linear_results;
  int rbf_results;
  int sat_results;
  int reg_writes;
  int random_words;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int bt = 31; bt >= 0; bt--) begin
      trial = r | (64'd1 << bt);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // exp(-gamma*sum) via 2^-y, fraction from the quantized power-of-two table
  function automatic logic [ACC_W-1:0] rbf_kernel(input logic [SUM_W-1:0] sq_sum,
                                                  input logic [GAMMA_W-1:0] g);
    logic [95:0]     prod;
    longint unsigned x;
    longint unsigned y;
    longint unsigned n;
    longint unsigned f;
    longint unsigned idx;
    longint unsigned q;
    longint unsigned r;
    prod = (96'(sq_sum) * 96'(g)) >> SCALE_SHIFT;
    x = (prod > 96'(X_LIMIT)) ? X_LIMIT : prod[63:0];
    y = (x * LOG2E + 64'd32768) >> 16;
    n = y >> 16;
    f = y & 64'hFFFF;
    idx = (f * TABLE_DEPTH) >> 16;
    q = (idx * 64'd65536) / TABLE_DEPTH;
    if (q > 64'd65535) q = 64'd65535;
    if (n >= 31) return '0;
    r = 64'd1 << 30;
    for (int k = 15; k >= 0; k--)
      if (q[k]) r = (r * exp_root[k] + (64'd1 << 29)) >> 30;
    return ACC_W'((r + (64'd1 << (13 + n))) >> (14 + n));
  endfunction

  task automatic accumulate_word(input logic signed [ELEM_W-1:0] a,
                                 input logic signed [ELEM_W-1:0] b,
                                 input logic last, output bit fires,
                                 output kernel_result_t res);
    longint d;
    longint term;
    longint total;
    if (pred_rbf) begin
      d = longint'(a) - longint'(b);
      term = d * d;
    end else begin
      term = longint'(a) * longint'(b);
    end
    total = longint'(pred_acc) + term;
    if (total > ACC_HI) begin
      total = ACC_HI;
      pred_sat = 1'b1;
    end else if (total < ACC_LO) begin
      total = ACC_LO;
      pred_sat = 1'b1;
    end
    pred_acc = total[ACC_W-1:0];
    fires = last;
    res = '0;
    if (last) begin
      if (pred_rbf) begin
        res.value = rbf_kernel(pred_acc[ACC_W-1] ? '0 : pred_acc[SUM_W-1:0], pred_gamma);
        rbf_results++;
      end else begin
        res.value = pred_acc;
        linear_results++;
      end
      res.ovf = pred_sat;
      if (pred_sat) sat_results++;
      pred_acc = '0;
      pred_sat = 1'b0;
    end
  endtask

  task automatic send_word(input logic signed [ELEM_W-1:0] a,
                           input logic signed [ELEM_W-1:0] b, input logic last,
                           input bit typed, input logic signed [ACC_W-1:0] typed_value,
                           input logic typed_ovf);
    kernel_result_t res;
    bit fires;
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_a_elem <= a;
    in_b_elem <= b;
    in_last   <= last;
    do @(posedge clk); while (!in_ready);
    word_count++;
    accumulate_word(a, b, last, fires, res);
    if (fires) begin
      if (typed) begin
        res.value = typed_value;
        res.ovf   = typed_ovf;
      end
      pending.push_back(res);
    end
  endtask

  // drain results, then give the RBF back end time to finish
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAMMA_W-1:0] data);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      IDX_MODE:  pred_rbf = data[0];
      IDX_GAMMA: pred_gamma = data;
      default: ;
    endcase
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_elem(input int bits);
    logic signed [ELEM_W-1:0] e;
    case ($urandom_range(9))
      0: e = 16'sh8000;
      1: e = 16'sh7FFF;
      default: begin
        e = ELEM_W'($urandom);
        e = e >>> (ELEM_W - bits);
      end
    endcase
    return e;
  endfunction

  function automatic logic [GAMMA_W-1:0] pick_gamma();
    case ($urandom_range(7))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return 24'h010000;
      default: return GAMMA_W'($urandom) >> $urandom_range(23);
    endcase
  endfunction

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word kernel_value=%0d overflow=%0b", $time,
                 out_kernel_value, out_overflow);
      end else begin
        oldest = pending.pop_front();
        if (out_kernel_value !== oldest.value) begin
          errors++;
          $display("%0t: kernel_value expected %0d actual %0d", $time, oldest.value,
                   out_kernel_value);
        end
        if (out_overflow !== oldest.ovf) begin
          errors++;
          $display("%0t: overflow expected %0b actual %0b", $time, oldest.ovf, out_overflow);
        end
      end
    end
  end

  initial begin
    longint unsigned t;
    int phase;
    int span;
    int len;
    int bits;
    t = 64'd1 << 29;
    for (int k = 15; k >= 0; k--) begin
      t = floor_root(t << 30);
      exp_root[k] = t;
    end
    pred_rbf     = 1'b0;
    pred_gamma   = GAMMA_RESET;
    pred_acc     = '0;
    pred_sat     = 1'b0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_a_elem    = '0;
    in_b_elem    = '0;
    in_last      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = IDX_MODE;
    cfg_wdata    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == ROW_REG)
        write_reg(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].reg_data);
      else
        send_word(DIRECTED_PLAN[i].a, DIRECTED_PLAN[i].b, DIRECTED_PLAN[i].last,
                  DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].value, DIRECTED_PLAN[i].ovf);
    end

    // random traffic; a vector may stay open across a register write
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      phase++;
      if (phase == 6)
        write_reg(IDX_MODE, 24'd1);
      else if ($urandom_range(1))
        write_reg(IDX_MODE, GAMMA_W'($urandom));
      if ($urandom_range(1))
        write_reg(IDX_GAMMA, pick_gamma());
      if ($urandom_range(7) == 0)
        write_reg($urandom_range(1) ? IDX_SPARE2 : IDX_SPARE3, GAMMA_W'($urandom));
      quiet = (phase == 3);
      span = quiet ? 250 : $urandom_range(30, 80);
      if (phase == 6) hold_request = 1'b1;
      while (span > 0) begin
        if (phase == 6) len = 1;
        else if ($urandom_range(9) == 0) len = $urandom_range(8, 40);
        else len = $urandom_range(1, 6);
        bits = $urandom_range(1, 16);
        for (int j = 0; j < len && span > 0; j++) begin
          send_word(pick_elem(bits), pick_elem(bits), j == len - 1, 1'b0, '0, 1'b0);
          span--;
          random_words++;
        end
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d words over %0d phases and %0d register writes.", word_count,
             phase, reg_writes);
    $display("Kernel values: %0d linear, %0d RBF, %0d of them saturated.", linear_results,
             rbf_results, sat_results);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
